// ===== src/color_space_convert_add_core_defines.svh =====
// assertion helpers for the color space convert/add core
`ifndef COLOR_SPACE_CONVERT_ADD_CORE_DEFINES_SVH
`define COLOR_SPACE_CONVERT_ADD_CORE_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define CSCA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while reset is asserted
`define CSCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/cscadd_pkg.sv =====
`default_nettype none

package cscadd_pkg;

	// coefficient format: signed Q3.16 kept as sign and magnitude
	localparam int COEF_FRAC = 16;
	localparam int COEF_W    = 18;

	localparam logic SPACE_XYZ  = 1'b0;
	localparam logic SPACE_SRGB = 1'b1;

	localparam logic OP_CONVERT = 1'b0;
	localparam logic OP_ADD     = 1'b1;

	typedef logic [COEF_W-1:0] coef_mag_t;

	typedef struct packed {
		logic      neg;
		coef_mag_t mag;
	} coef_t;

	// linear sRGB to XYZ
	localparam coef_t TO_XYZ_COEF [3][3] = '{
		'{ '{1'b0, 18'd27031}, '{1'b0, 18'd23434}, '{1'b0, 18'd11825} },
		'{ '{1'b0, 18'd13938}, '{1'b0, 18'd46868}, '{1'b0, 18'd4730}  },
		'{ '{1'b0, 18'd1267},  '{1'b0, 18'd7811},  '{1'b0, 18'd62279} }
	};

	// XYZ to linear sRGB
	localparam coef_t TO_SRGB_COEF [3][3] = '{
		'{ '{1'b0, 18'd212366}, '{1'b1, 18'd100738}, '{1'b1, 18'd32672} },
		'{ '{1'b1, 18'd63522},  '{1'b0, 18'd122946}, '{1'b0, 18'd2723}  },
		'{ '{1'b0, 18'd3647},   '{1'b1, 18'd13371},  '{1'b0, 18'd69286} }
	};

	// per-item control carried down the pipe
	typedef struct packed {
		logic conv;   // matrix applies
		logic tgt;    // target space
		logic black;  // first color all zero
	} ctrl_t;

endpackage

`default_nettype wire

// ===== src/color_space_convert_add_core.sv =====
// channel | direction | handshake             | payload
// in      | into core | in_valid / in_stall   | operation, a_ch0..2, a_space,
//         |           |                       | b_ch0..2, b_space, target_space
// out     | from core | out_valid / out_stall | out_ch0..2, out_space, is_black
//
// throughput: one item per cycle, sustained, with no stall on the output side
// path: an accepted item passes the s1 -> s2 -> output register chain (operand select,
// products, sums) and is offered to the receiver from the output register
// reset: arst_n clears only the stage valid bits; payload registers are not reset
// stalls: out_stall holds the output register; bubbles in s1/s2 still fill, so
// in_stall rises only when all three stages hold items and the output is stalled

`default_nettype none

`include "color_space_convert_add_core_defines.svh"

module color_space_convert_add_core #(
	parameter int CHANNEL_WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     in_valid,
	output      logic                     in_stall,
	input  wire logic                     operation,
	input  wire logic [CHANNEL_WIDTH-1:0] a_ch0,
	input  wire logic [CHANNEL_WIDTH-1:0] a_ch1,
	input  wire logic [CHANNEL_WIDTH-1:0] a_ch2,
	input  wire logic                     a_space,
	input  wire logic [CHANNEL_WIDTH-1:0] b_ch0,
	input  wire logic [CHANNEL_WIDTH-1:0] b_ch1,
	input  wire logic [CHANNEL_WIDTH-1:0] b_ch2,
	input  wire logic                     b_space,
	input  wire logic                     target_space,

	output      logic                     out_valid,
	input  wire logic                     out_stall,
	output      logic [CHANNEL_WIDTH-1:0] out_ch0,
	output      logic [CHANNEL_WIDTH-1:0] out_ch1,
	output      logic [CHANNEL_WIDTH-1:0] out_ch2,
	output      logic                     out_space,
	output      logic                     is_black
);
	import cscadd_pkg::*;

	// matrix operand may be the sum of two channels: one extra bit
	localparam int MW  = CHANNEL_WIDTH + 1;
	// full product width and the width after dropping the coefficient fraction
	localparam int FW  = MW + COEF_W;
	localparam int PW  = FW - COEF_FRAC;
	// row sums of three products plus the addend, with headroom
	localparam int SW  = PW + 3;

	// ---------------------------------------------------------------
	// handshake: each stage moves when the stage after it can take it
	// ---------------------------------------------------------------
	logic v_s1, v_s2, out_valid_q;
	logic en_s1, en_s2, en_out;

	assign en_out   = !out_valid_q || !out_stall;
	assign en_s2    = !v_s2 || en_out;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// ---------------------------------------------------------------
	// operand select: pick what goes through the matrix and what is
	// added afterwards
	// ---------------------------------------------------------------
	logic [CHANNEL_WIDTH-1:0] a_v [3];
	logic [CHANNEL_WIDTH-1:0] b_v [3];
	logic [MW-1:0]            mat_d [3];
	logic [CHANNEL_WIDTH-1:0] add_d [3];
	ctrl_t                    ctrl_d;

	assign a_v[0] = a_ch0;
	assign a_v[1] = a_ch1;
	assign a_v[2] = a_ch2;
	assign b_v[0] = b_ch0;
	assign b_v[1] = b_ch1;
	assign b_v[2] = b_ch2;

	always_comb begin
		ctrl_d.tgt   = target_space;
		ctrl_d.black = (a_ch0 == '0) && (a_ch1 == '0) && (a_ch2 == '0);
		ctrl_d.conv  = 1'b1;
		for (int i = 0; i < 3; i++) begin
			mat_d[i] = MW'(a_v[i]);
			add_d[i] = '0;
		end
		if (operation == OP_CONVERT) begin
			// single color, straight through when already in target space
			ctrl_d.conv = (a_space != target_space);
		end else if (a_space == b_space) begin
			// same space: sum first, then convert the sum
			ctrl_d.conv = (a_space != target_space);
			for (int i = 0; i < 3; i++) begin
				mat_d[i] = MW'(a_v[i]) + MW'(b_v[i]);
			end
		end else if (a_space == target_space) begin
			// second color needs converting, first is added as is
			for (int i = 0; i < 3; i++) begin
				mat_d[i] = MW'(b_v[i]);
				add_d[i] = a_v[i];
			end
		end else begin
			// first color needs converting, second is added as is
			for (int i = 0; i < 3; i++) begin
				add_d[i] = b_v[i];
			end
		end
	end

	// stage 1 register
	logic [MW-1:0]            mat_s1 [3];
	logic [CHANNEL_WIDTH-1:0] add_s1 [3];
	ctrl_t                    ctrl_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			mat_s1  <= mat_d;
			add_s1  <= add_d;
			ctrl_s1 <= ctrl_d;
		end
	end

	// ---------------------------------------------------------------
	// nine products by coefficient magnitude, fraction truncated
	// ---------------------------------------------------------------
	logic [FW-1:0] prod_full [3][3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (ctrl_s1.tgt == SPACE_SRGB) begin
					prod_full[r][c] = FW'(mat_s1[c]) * FW'(TO_SRGB_COEF[r][c].mag);
				end else begin
					prod_full[r][c] = FW'(mat_s1[c]) * FW'(TO_XYZ_COEF[r][c].mag);
				end
			end
		end
	end

	// stage 2 register
	logic [PW-1:0]            prod_s2 [3][3];
	logic [MW-1:0]            mat_s2 [3];
	logic [CHANNEL_WIDTH-1:0] add_s2 [3];
	ctrl_t                    ctrl_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= prod_full[r][c][FW-1:COEF_FRAC];
				end
			end
			mat_s2  <= mat_s1;
			add_s2  <= add_s1;
			ctrl_s2 <= ctrl_s1;
		end
	end

	// ---------------------------------------------------------------
	// signed row sums, clamp at zero, add the other color, saturate
	// ---------------------------------------------------------------
	logic [SW-1:0]            pos_sum [3];
	logic [SW-1:0]            neg_sum [3];
	logic [SW-1:0]            row_res [3];
	logic [CHANNEL_WIDTH-1:0] sat_d   [3];
	logic                     neg_k;

	always_comb begin
		neg_k = 1'b0;
		for (int r = 0; r < 3; r++) begin
			pos_sum[r] = '0;
			neg_sum[r] = '0;
			for (int c = 0; c < 3; c++) begin
				if (ctrl_s2.tgt == SPACE_SRGB) begin
					neg_k = TO_SRGB_COEF[r][c].neg;
				end else begin
					neg_k = TO_XYZ_COEF[r][c].neg;
				end
				if (neg_k) begin
					neg_sum[r] = neg_sum[r] + SW'(prod_s2[r][c]);
				end else begin
					pos_sum[r] = pos_sum[r] + SW'(prod_s2[r][c]);
				end
			end
			if (!ctrl_s2.conv) begin
				row_res[r] = SW'(mat_s2[r]);
			end else if (pos_sum[r] > neg_sum[r]) begin
				row_res[r] = pos_sum[r] - neg_sum[r] + SW'(add_s2[r]);
			end else begin
				row_res[r] = SW'(add_s2[r]);
			end
			// anything above the channel width saturates
			if (|row_res[r][SW-1:CHANNEL_WIDTH]) begin
				sat_d[r] = '1;
			end else begin
				sat_d[r] = row_res[r][CHANNEL_WIDTH-1:0];
			end
		end
	end

	// output register
	logic [CHANNEL_WIDTH-1:0] out_ch_q [3];
	logic                     out_space_q;
	logic                     is_black_q;

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			out_ch_q    <= sat_d;
			out_space_q <= ctrl_s2.tgt;
			is_black_q  <= ctrl_s2.black;
		end
	end

	assign out_ch0   = out_ch_q[0];
	assign out_ch1   = out_ch_q[1];
	assign out_ch2   = out_ch_q[2];
	assign out_space = out_space_q;
	assign is_black  = is_black_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------

	// input side only backs up once every stage is occupied and the output waits
	`CSCA_ASSERT_SAME(a_stall_full, clk, arst_n, in_stall,
		v_s1 && v_s2 && out_valid_q && out_stall, "in_stall with a free stage")

	// an item leaving stage 1 shows up in stage 2
	`CSCA_ASSERT_NEXT(a_s1_to_s2, clk, arst_n, v_s1 && en_s2, v_s2,
		"item lost between stage 1 and stage 2")

	// a delivered result with nothing behind it leaves the output empty
	`CSCA_ASSERT_NEXT(a_out_drain, clk, arst_n, out_valid_q && !out_stall && !v_s2,
		!out_valid_q, "result repeated after delivery")

endmodule

`default_nettype wire

// ===== sim/color_space_convert_add_checker.sv =====
`timescale 1ns / 1ps

module color_space_convert_add_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        operation,
	input  wire logic [31:0] a_ch0,
	input  wire logic [31:0] a_ch1,
	input  wire logic [31:0] a_ch2,
	input  wire logic        a_space,
	input  wire logic [31:0] b_ch0,
	input  wire logic [31:0] b_ch1,
	input  wire logic [31:0] b_ch2,
	input  wire logic        b_space,
	input  wire logic        target_space,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [31:0] out_ch0,
	input  wire logic [31:0] out_ch1,
	input  wire logic [31:0] out_ch2,
	input  wire logic        out_space,
	input  wire logic        is_black,
	output int               mismatch_count,
	output int               owed_count
);
	import cscadd_pkg::*;

	localparam longint unsigned CH_SAT = 64'h0000_0000_FFFF_FFFF;

	typedef logic [2:0][63:0] color_trip_t;

	typedef struct packed {
		logic [31:0] ch0;
		logic [31:0] ch1;
		logic [31:0] ch2;
		logic        space;
		logic        black;
	} color_result_t;

	color_result_t owed_colors[$];

	// signed Q3.16 matrix entries
	function automatic int mix_coef(input logic to_srgb, input int row, input int col);
		int idx;
		idx = row * 3 + col;
		if (to_srgb) begin
			case (idx)
				0: return 212366;
				1: return -100738;
				2: return -32672;
				3: return -63522;
				4: return 122946;
				5: return 2723;
				6: return 3647;
				7: return -13371;
				default: return 69286;
			endcase
		end else begin
			case (idx)
				0: return 27031;
				1: return 23434;
				2: return 11825;
				3: return 13938;
				4: return 46868;
				5: return 4730;
				6: return 1267;
				7: return 7811;
				default: return 62279;
			endcase
		end
	endfunction

	// positive and negative terms kept apart, each truncated, clamp at zero
	function automatic color_trip_t mix_color(input logic to_srgb, input color_trip_t v);
		color_trip_t     r;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned mag;
		int              k;
		int              i;
		int              j;
		for (i = 0; i < 3; i++) begin
			pos = 0;
			neg = 0;
			for (j = 0; j < 3; j++) begin
				k = mix_coef(to_srgb, i, j);
				mag = (k < 0) ? longint'(-k) : longint'(k);
				if (k < 0)
					neg += (v[j] * mag) >> 16;
				else
					pos += (v[j] * mag) >> 16;
			end
			r[i] = (pos > neg) ? pos - neg : 64'd0;
		end
		return r;
	endfunction

	function automatic color_trip_t to_space(input color_trip_t v, input logic from_sp,
			input logic to_sp);
		if (from_sp == to_sp)
			return v;
		return mix_color(to_sp == SPACE_SRGB, v);
	endfunction

	function automatic color_result_t predict_color(
		input logic op, input logic [31:0] a0, a1, a2, input logic sa,
		input logic [31:0] b0, b1, b2, input logic sb, input logic tgt
	);
		color_trip_t   a;
		color_trip_t   b;
		color_trip_t   t;
		color_trip_t   res;
		color_result_t r;
		int            i;
		a[0] = a0; a[1] = a1; a[2] = a2;
		b[0] = b0; b[1] = b1; b[2] = b2;
		if (op == OP_CONVERT) begin
			res = to_space(a, sa, tgt);
		end else if (sa == sb) begin
			for (i = 0; i < 3; i++)
				t[i] = a[i] + b[i];
			res = to_space(t, sa, tgt);
		end else if (sa == tgt) begin
			t = to_space(b, sb, tgt);
			for (i = 0; i < 3; i++)
				res[i] = a[i] + t[i];
		end else begin
			t = to_space(a, sa, tgt);
			for (i = 0; i < 3; i++)
				res[i] = t[i] + b[i];
		end
		for (i = 0; i < 3; i++)
			if (res[i] > CH_SAT)
				res[i] = CH_SAT;
		r.ch0   = res[0][31:0];
		r.ch1   = res[1][31:0];
		r.ch2   = res[2][31:0];
		r.space = tgt;
		r.black = (a0 == 0) && (a1 == 0) && (a2 == 0);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got, inout int errs);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk) begin
		color_result_t want;
		int            errs;
		errs = 0;
		if (arst_n) begin
			if (in_valid && !in_stall)
				owed_colors.push_back(predict_color(operation, a_ch0, a_ch1, a_ch2, a_space,
					b_ch0, b_ch1, b_ch2, b_space, target_space));
			if (out_valid && !out_stall) begin
				if (owed_colors.size() == 0) begin
					$error("result item with no input item owed");
					errs++;
				end else begin
					want = owed_colors.pop_front();
					check_field("out_ch0", want.ch0, out_ch0, errs);
					check_field("out_ch1", want.ch1, out_ch1, errs);
					check_field("out_ch2", want.ch2, out_ch2, errs);
					check_field("out_space", 32'(want.space), 32'(out_space), errs);
					check_field("is_black", 32'(want.black), 32'(is_black), errs);
				end
			end
		end
		mismatch_count <= mismatch_count + errs;
		owed_count     <= owed_colors.size();
	end

endmodule

// ===== sim/tb_color_space_convert_add_core.sv =====
`timescale 1ns / 1ps

module tb_color_space_convert_add_core;

	import cscadd_pkg::*;

	// run guard, far above the slowest legal run
	localparam int CYCLE_LIMIT = 200000;
	// length of the receiver hold-off that fills the pipe
	localparam int HOLD_LEN    = 40;
	localparam int RANDOM_ITEMS = 800;

	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] CMAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        op;
		logic [31:0] a0;
		logic [31:0] a1;
		logic [31:0] a2;
		logic        sa;
		logic [31:0] b0;
		logic [31:0] b1;
		logic [31:0] b2;
		logic        sb;
		logic        tgt;
	} color_item_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        operation    = OP_CONVERT;
	logic [31:0] a_ch0        = '0;
	logic [31:0] a_ch1        = '0;
	logic [31:0] a_ch2        = '0;
	logic        a_space      = SPACE_XYZ;
	logic [31:0] b_ch0        = '0;
	logic [31:0] b_ch1        = '0;
	logic [31:0] b_ch2        = '0;
	logic        b_space      = SPACE_XYZ;
	logic        target_space = SPACE_XYZ;
	logic        out_stall    = 1'b0;

	logic        in_stall;
	logic        out_valid;
	logic [31:0] out_ch0;
	logic [31:0] out_ch1;
	logic [31:0] out_ch2;
	logic        out_space;
	logic        is_black;

	int mismatch_count;
	int owed_count;

	// idle and stall odds in percent, set per phase
	int idle_pct  = 0;
	int stall_pct = 0;

	// receiver hold-off control, the counter lives in the receiver process
	logic pressure_go = 1'b0;
	logic hold_done   = 1'b0;
	int   hold_cycles = 0;

	int cycle_count = 0;

	always #1 clk = ~clk;

	color_space_convert_add_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.a_ch0        (a_ch0),
		.a_ch1        (a_ch1),
		.a_ch2        (a_ch2),
		.a_space      (a_space),
		.b_ch0        (b_ch0),
		.b_ch1        (b_ch1),
		.b_ch2        (b_ch2),
		.b_space      (b_space),
		.target_space (target_space),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_ch0      (out_ch0),
		.out_ch1      (out_ch1),
		.out_ch2      (out_ch2),
		.out_space    (out_space),
		.is_black     (is_black)
	);

	// watches both channels, predicts every result and compares
	color_space_convert_add_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.a_ch0          (a_ch0),
		.a_ch1          (a_ch1),
		.a_ch2          (a_ch2),
		.a_space        (a_space),
		.b_ch0          (b_ch0),
		.b_ch1          (b_ch1),
		.b_ch2          (b_ch2),
		.b_space        (b_space),
		.target_space   (target_space),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_ch0        (out_ch0),
		.out_ch1        (out_ch1),
		.out_ch2        (out_ch2),
		.out_space      (out_space),
		.is_black       (is_black),
		.mismatch_count (mismatch_count),
		.owed_count     (owed_count)
	);

	// receiver: one long hold-off when asked, random stalls otherwise
	always @(posedge clk) begin
		if (pressure_go && !hold_done) begin
			if (hold_cycles < HOLD_LEN) begin
				out_stall   <= 1'b1;
				hold_cycles <= hold_cycles + 1;
			end else begin
				out_stall <= 1'b0;
				hold_done <= 1'b1;
			end
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_color_space_convert_add_core failed");
			$finish;
		end
	end

	function automatic color_item_t make_item(
		input logic op, input logic [31:0] a0, a1, a2, input logic sa,
		input logic [31:0] b0, b1, b2, input logic sb, input logic tgt
	);
		color_item_t it;
		it.op = op;
		it.a0 = a0; it.a1 = a1; it.a2 = a2; it.sa = sa;
		it.b0 = b0; it.b1 = b1; it.b2 = b2; it.sb = sb;
		it.tgt = tgt;
		return it;
	endfunction

	// channel values lean toward the edges: zero, full scale, small values up to three, single bits
	function automatic logic [31:0] pick_channel();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return CMAX;
			2: return 32'($urandom_range(32'h0003_0000));
			3: return 32'd1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	function automatic color_item_t random_item();
		color_item_t it;
		it.op  = 1'($urandom_range(1));
		it.a0  = pick_channel();
		it.a1  = pick_channel();
		it.a2  = pick_channel();
		it.sa  = 1'($urandom_range(1));
		it.b0  = pick_channel();
		it.b1  = pick_channel();
		it.b2  = pick_channel();
		it.sb  = 1'($urandom_range(1));
		it.tgt = 1'($urandom_range(1));
		// some black first colors so the flag is seen in both operations
		if ($urandom_range(19) == 0) begin
			it.a0 = '0;
			it.a1 = '0;
			it.a2 = '0;
		end
		return it;
	endfunction

	// offer one item, with random idle cycles ahead of it, and wait for acceptance
	task automatic offer_item(input color_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= it.op;
		a_ch0        <= it.a0;
		a_ch1        <= it.a1;
		a_ch2        <= it.a2;
		a_space      <= it.sa;
		b_ch0        <= it.b0;
		b_ch1        <= it.b1;
		b_ch2        <= it.b2;
		b_space      <= it.sb;
		target_space <= it.tgt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	initial begin
		int i;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, back to back
		// black first color, passes through unchanged
		offer_item(make_item(OP_CONVERT, 0, 0, 0, SPACE_XYZ, 0, 0, 0, SPACE_XYZ, SPACE_XYZ));
		// full scale pass-through, second color ignored on convert
		offer_item(make_item(OP_CONVERT, CMAX, CMAX, CMAX, SPACE_SRGB,
			32'h1234_5678, CMAX, 1, SPACE_XYZ, SPACE_SRGB));
		// full scale sRGB into XYZ
		offer_item(make_item(OP_CONVERT, CMAX, CMAX, CMAX, SPACE_SRGB,
			0, 0, 0, SPACE_SRGB, SPACE_XYZ));
		// full scale XYZ into sRGB, red row saturates
		offer_item(make_item(OP_CONVERT, CMAX, CMAX, CMAX, SPACE_XYZ,
			0, 0, 0, SPACE_XYZ, SPACE_SRGB));
		// only Y present: red and blue go negative and clamp to zero
		offer_item(make_item(OP_CONVERT, 0, CMAX, 0, SPACE_XYZ,
			0, 0, 0, SPACE_XYZ, SPACE_SRGB));
		// only X present: green goes negative
		offer_item(make_item(OP_CONVERT, 32'h0002_0000, 0, 0, SPACE_XYZ,
			CMAX, CMAX, CMAX, SPACE_SRGB, SPACE_SRGB));
		// black sRGB into XYZ
		offer_item(make_item(OP_CONVERT, 0, 0, 0, SPACE_SRGB,
			CMAX, CMAX, CMAX, SPACE_SRGB, SPACE_XYZ));
		// tiny values truncate toward zero
		offer_item(make_item(OP_CONVERT, 1, 1, 1, SPACE_SRGB, 0, 0, 0, SPACE_XYZ, SPACE_XYZ));
		// add, every combination of the three space selects
		for (i = 0; i < 8; i++)
			offer_item(make_item(OP_ADD, ONE, ONE >> 1, ONE * 3, i[2],
				ONE >> 2, ONE * 2, ONE, i[1], i[0]));
		// same-space sum overflows and saturates
		offer_item(make_item(OP_ADD, CMAX, CMAX, CMAX, SPACE_XYZ,
			CMAX, CMAX, CMAX, SPACE_XYZ, SPACE_XYZ));
		// same-space sum kept wide before the matrix
		offer_item(make_item(OP_ADD, CMAX, CMAX, CMAX, SPACE_SRGB,
			CMAX, CMAX, CMAX, SPACE_SRGB, SPACE_XYZ));
		// black first color on add, second color nonzero
		offer_item(make_item(OP_ADD, 0, 0, 0, SPACE_XYZ,
			ONE, ONE, ONE, SPACE_SRGB, SPACE_XYZ));
		// mixed spaces at full scale, converted addend plus the other saturates
		offer_item(make_item(OP_ADD, CMAX, CMAX, CMAX, SPACE_XYZ,
			CMAX, CMAX, CMAX, SPACE_SRGB, SPACE_SRGB));
		// XYZ sum into sRGB with clamping
		offer_item(make_item(OP_ADD, 0, ONE * 4, 0, SPACE_XYZ,
			0, ONE * 4, 0, SPACE_XYZ, SPACE_SRGB));

		// random part in four idling phases
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 200)
				idle_pct = 57;
			if (i == 400) begin
				idle_pct  = 0;
				stall_pct = 57;
			end
			if (i == 600) begin
				idle_pct  = 21;
				stall_pct = 21;
			end
			// long receiver hold-off while items keep coming, fills the pipe
			if (i == 100)
				pressure_go <= 1'b1;
			offer_item(random_item());
		end
		in_valid <= 1'b0;

		// drain: wait until every owed result is back before the verdict
		@(posedge clk);
		while (owed_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_color_space_convert_add_core passed");
		else
			$display("tb_color_space_convert_add_core failed");
		$finish;
	end

endmodule
